[rtl/core/kpm_pkg.sv]
// Shared types and constants for the keepalive ping monitor.
`default_nettype none

package kpm_pkg;

  localparam int TIME_WIDTH_DEF = 48;
  localparam int CFG_W          = 20;
  localparam int ID_W           = 16;
  localparam int RT_W           = 16;
  localparam int CFG_IDX_W      = 3;

  localparam logic [CFG_W-1:0] PING_INTERVAL_RST     = CFG_W'(1000);
  localparam logic [CFG_W-1:0] PING_TIMEOUT_RST      = CFG_W'(5000);
  localparam logic [CFG_W-1:0] RECOVERY_INTERVAL_RST = CFG_W'(1000);
  localparam logic [CFG_W-1:0] RECOVERY_TIMEOUT_RST  = CFG_W'(15000);
  localparam logic [ID_W-1:0]  PING_ID_RST           = '0;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_PONG = 2'd1,
    KIND_ACK  = 2'd2,
    KIND_RSVD = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PING_INTERVAL     = 3'd0,
    REG_PING_TIMEOUT      = 3'd1,
    REG_RECOVERY_INTERVAL = 3'd2,
    REG_RECOVERY_TIMEOUT  = 3'd3,
    REG_PING_ID           = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] ping_interval;
    logic [CFG_W-1:0] ping_timeout;
    logic [CFG_W-1:0] recovery_interval;
    logic [CFG_W-1:0] recovery_timeout;
    logic [ID_W-1:0]  ping_id;
  } cfg_t;

  typedef struct packed {
    logic            send_ping;
    logic [ID_W-1:0] ping_id_out;
    logic            send_recovery;
    logic            timed_out;
    logic [RT_W-1:0] round_trip_ms;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/kpm_if.sv]
// Valid/ready channel interfaces for event items and result items.
`default_nettype none

interface kpm_in_if #(parameter int TIME_WIDTH = 48);
  logic                  valid;
  logic                  ready;
  logic [1:0]            kind;
  logic [TIME_WIDTH-1:0] now_ms;
  logic [15:0]           pong_id;

  modport source (output valid, kind, now_ms, pong_id, input ready);
  modport sink   (input valid, kind, now_ms, pong_id, output ready);
endinterface

interface kpm_out_if;
  logic        valid;
  logic        ready;
  logic        send_ping;
  logic [15:0] ping_id_out;
  logic        send_recovery;
  logic        timed_out;
  logic [15:0] round_trip_ms;

  modport source (output valid, send_ping, ping_id_out, send_recovery, timed_out,
                  round_trip_ms, input ready);
  modport sink   (input valid, send_ping, ping_id_out, send_recovery, timed_out,
                  round_trip_ms, output ready);
endinterface

`default_nettype wire

[rtl/core/kpm_cfg.sv]
// Configuration register file of the keepalive ping monitor.
`default_nettype none

module kpm_cfg
  import kpm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                      cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        REG_PING_INTERVAL:     cfg_nxt.ping_interval     = cfg_wdata;
        REG_PING_TIMEOUT:      cfg_nxt.ping_timeout      = cfg_wdata;
        REG_RECOVERY_INTERVAL: cfg_nxt.recovery_interval = cfg_wdata;
        REG_RECOVERY_TIMEOUT:  cfg_nxt.recovery_timeout  = cfg_wdata;
        REG_PING_ID:           cfg_nxt.ping_id           = cfg_wdata[ID_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ping_interval     <= PING_INTERVAL_RST;
      cfg_r.ping_timeout      <= PING_TIMEOUT_RST;
      cfg_r.recovery_interval <= RECOVERY_INTERVAL_RST;
      cfg_r.recovery_timeout  <= RECOVERY_TIMEOUT_RST;
      cfg_r.ping_id           <= PING_ID_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[rtl/core/kpm_core.sv]
// Timestamp state and combinational event evaluation.
`default_nettype none

module kpm_core
  import kpm_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  fire,
  input  wire logic [1:0]            kind,
  input  wire logic [TIME_WIDTH-1:0] now_ms,
  input  wire logic [ID_W-1:0]       pong_id,
  input  wire cfg_t                  cfg,
  output res_t                       res
);

  localparam int TW = TIME_WIDTH;

  logic [TW-1:0]   request_time_r,     request_time_nxt;
  logic [TW-1:0]   response_time_r,    response_time_nxt;
  logic [TW-1:0]   recovery_time_r,    recovery_time_nxt;
  logic [TW-1:0]   acknowledge_time_r, acknowledge_time_nxt;
  logic [RT_W-1:0] round_trip_r,       round_trip_nxt;

  // now strictly after last and more than span later
  function automatic logic elapsed(input logic [TW-1:0] last,
                                   input logic [CFG_W-1:0] span,
                                   input logic [TW-1:0] now);
    logic [TW:0] diff;
    diff = {1'b0, now} - {1'b0, last};
    return !diff[TW] && (diff[TW-1:0] > {{(TW-CFG_W){1'b0}}, span});
  endfunction

  logic          is_tick, is_pong_hit, is_ack;
  logic          ping, resp_zero, ack_zero, ping_late, rec, tout;
  logic [TW:0]   rt_diff;
  logic [TW-1:0] rt_val;

  always_comb begin
    is_tick     = kind == KIND_TICK;
    is_pong_hit = (kind == KIND_PONG) && (pong_id == cfg.ping_id);
    is_ack      = kind == KIND_ACK;
    resp_zero   = response_time_r == '0;
    ack_zero    = acknowledge_time_r == '0;

    ping = is_tick && elapsed(request_time_r, cfg.ping_interval, now_ms);
    // a response time freshly set to now can never count as elapsed
    ping_late = is_tick && !(ping && resp_zero)
                && elapsed(response_time_r, cfg.ping_timeout, now_ms);
    rec  = ping_late && elapsed(recovery_time_r, cfg.recovery_interval, now_ms);
    tout = ping_late && !(rec && ack_zero)
           && elapsed(acknowledge_time_r, cfg.recovery_timeout, now_ms);

    // round trip, clamped at zero when time runs backwards
    rt_diff = {1'b0, now_ms} - {1'b0, request_time_r};
    rt_val  = rt_diff[TW] ? '0 : rt_diff[TW-1:0];

    request_time_nxt     = ping ? now_ms : request_time_r;
    recovery_time_nxt    = rec ? now_ms : recovery_time_r;
    response_time_nxt    = response_time_r;
    acknowledge_time_nxt = acknowledge_time_r;
    round_trip_nxt       = round_trip_r;
    if ((ping && resp_zero) || is_pong_hit) begin
      response_time_nxt = now_ms;
    end
    if ((rec && ack_zero) || is_pong_hit || is_ack) begin
      acknowledge_time_nxt = now_ms;
    end
    if (is_pong_hit) begin
      round_trip_nxt = (rt_val[TW-1:RT_W] != '0) ? '1 : rt_val[RT_W-1:0];
    end

    res.send_ping     = ping;
    res.ping_id_out   = ping ? cfg.ping_id : '0;
    res.send_recovery = rec;
    res.timed_out     = tout;
    res.round_trip_ms = round_trip_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      request_time_r     <= '0;
      response_time_r    <= '0;
      recovery_time_r    <= '0;
      acknowledge_time_r <= '0;
      round_trip_r       <= '0;
    end else if (fire) begin
      request_time_r     <= request_time_nxt;
      response_time_r    <= response_time_nxt;
      recovery_time_r    <= recovery_time_nxt;
      acknowledge_time_r <= acknowledge_time_nxt;
      round_trip_r       <= round_trip_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/keepalive_ping_monitor.sv]
// Path: an item waits in the input register, its result in the output register.
// Throughput: one item per cycle unless the output stalls; the input register,
//   evaluation on stored timestamps and output register form a two-stage pipeline.
// Back pressure: the input side stays ready while the output register drains.
// Reset (rst_n low, synchronous): pipeline empty, timestamps and round trip zero,
//   configuration registers at their default values.
`default_nettype none

module keepalive_ping_monitor
  import kpm_pkg::*;
#(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  kpm_in_if.sink                    in_ch,
  kpm_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t cfg;

  kpm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // ---------------------------------------------------------------------------
  // Input register stage
  // ---------------------------------------------------------------------------
  logic                  s1_valid_r;
  logic [1:0]            s1_kind_r;
  logic [TIME_WIDTH-1:0] s1_now_r;
  logic [ID_W-1:0]       s1_pong_id_r;

  logic out_valid_r;
  res_t out_res_r;
  res_t res;

  logic in_fire, advance;

  // Stage 1 moves into the output register when that one is empty or draining.
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r    <= in_ch.kind;
      s1_now_r     <= in_ch.now_ms;
      s1_pong_id_r <= in_ch.pong_id;
    end
  end

  // ---------------------------------------------------------------------------
  // Evaluation against stored timestamps; state commits when the item advances
  // so the following item already sees the updated times.
  // ---------------------------------------------------------------------------
  kpm_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .kind    (s1_kind_r),
    .now_ms  (s1_now_r),
    .pong_id (s1_pong_id_r),
    .cfg     (cfg),
    .res     (res)
  );

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.send_ping     = out_res_r.send_ping;
  assign out_ch.ping_id_out   = out_res_r.ping_id_out;
  assign out_ch.send_recovery = out_res_r.send_recovery;
  assign out_ch.timed_out     = out_res_r.timed_out;
  assign out_ch.round_trip_ms = out_res_r.round_trip_ms;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a stalled item in stage 1 stays there
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r)
    else $error("stage 1 item lost while stalled");

  // only ticks raise any request or timeout flag
  a_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (s1_kind_r != KIND_TICK) |->
      !res.send_ping && !res.send_recovery && !res.timed_out)
    else $error("flag raised on a non-tick item");

  // ping identifier is zero unless a ping goes out
  a_ping_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.send_ping |-> out_res_r.ping_id_out == '0)
    else $error("ping identifier without ping");

  // an item advancing into a full, stalled output register would overwrite it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !advance)
    else $error("output register overwritten");

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the keepalive ping monitor: directed and random event items.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kpm_pkg::*;

  typedef logic [TIME_WIDTH_DEF-1:0] stamp_t;

  // Cycles with no item moving on either channel and no register write
  // before the run is declared hung. Worst legal gap is the longest send
  // gap plus the longest receive stall plus pipeline depth.
  localparam int STALL_LIMIT = 1000;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  kpm_in_if #(.TIME_WIDTH(TIME_WIDTH_DEF)) in_ch ();
  kpm_out_if out_ch ();

  keepalive_ping_monitor #(.TIME_WIDTH(TIME_WIDTH_DEF)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // Predictor state: our own copy of the monitor's timestamps and settings
  // ---------------------------------------------------------------------
  cfg_t   settings = '{PING_INTERVAL_RST, PING_TIMEOUT_RST, RECOVERY_INTERVAL_RST,
                       RECOVERY_TIMEOUT_RST, PING_ID_RST};
  stamp_t last_ping_ms     = '0;   // time of the last ping request
  stamp_t last_pong_ms     = '0;   // time of the last matching pong
  stamp_t last_recovery_ms = '0;   // time of the last recovery request
  stamp_t last_ack_ms      = '0;   // time of the last acknowledge
  logic [RT_W-1:0] rtt_ms  = '0;   // latest round trip

  res_t   pending_results[$];      // expected result items, oldest first
  int     failures    = 0;
  int     idle_cycles = 0;
  bit     steady      = 1'b0;      // when set, neither side idles
  stamp_t session_ms;              // running clock of the random sessions

  // ---------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // "last + span < now" without wrap: time must move forward, and by more
  // than the span. A zero stamp is just a time, so zero-last fires early.
  function automatic bit span_passed(stamp_t last, logic [CFG_W-1:0] span, stamp_t now);
    return (now > last) && ((now - last) > stamp_t'(span));
  endfunction

  // Advances the predictor by one event item and returns the result it causes.
  function automatic res_t evaluate_event(kind_e kind, stamp_t now, logic [ID_W-1:0] pid);
    res_t   r;
    stamp_t trip;
    r = '0;
    case (kind)
      KIND_TICK: begin
        // ping first; a first ping also seeds the response time
        if (span_passed(last_ping_ms, settings.ping_interval, now)) begin
          if (last_pong_ms == '0) last_pong_ms = now;
          last_ping_ms  = now;
          r.send_ping   = 1'b1;
          r.ping_id_out = settings.ping_id;
        end
        // silence check sees the response time updated above
        if (span_passed(last_pong_ms, settings.ping_timeout, now)) begin
          if (span_passed(last_recovery_ms, settings.recovery_interval, now)) begin
            if (last_ack_ms == '0) last_ack_ms = now;
            last_recovery_ms = now;
            r.send_recovery  = 1'b1;
          end
          if (span_passed(last_ack_ms, settings.recovery_timeout, now)) r.timed_out = 1'b1;
        end
      end
      KIND_PONG: begin
        // other identifiers are dropped without touching state
        if (pid == settings.ping_id) begin
          trip   = (now > last_ping_ms) ? now - last_ping_ms : '0;
          rtt_ms = (trip > stamp_t'(16'hFFFF)) ? 16'hFFFF : trip[RT_W-1:0];
          last_pong_ms = now;
          last_ack_ms  = now;
        end
      end
      KIND_ACK: last_ack_ms = now;
      default: ;  // reserved kind is ignored
    endcase
    r.round_trip_ms = rtt_ms;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Scoreboard: both channels sampled at the edge, before any update lands.
  // The result side is checked before the event side so the queue order
  // holds when both move on the same edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    res_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display({"%0t: result item with nothing expected, ",
                    "actual ping=%0h id=%0h rec=%0h to=%0h rt=%0h"},
                   $time, out_ch.send_ping, out_ch.ping_id_out, out_ch.send_recovery,
                   out_ch.timed_out, out_ch.round_trip_ms);
          failures++;
        end else begin
          want = pending_results.pop_front();
          check_field("send_ping",     16'(want.send_ping),     16'(out_ch.send_ping));
          check_field("ping_id_out",   want.ping_id_out,        out_ch.ping_id_out);
          check_field("send_recovery", 16'(want.send_recovery), 16'(out_ch.send_recovery));
          check_field("timed_out",     16'(want.timed_out),     16'(out_ch.timed_out));
          check_field("round_trip_ms", want.round_trip_ms,      out_ch.round_trip_ms);
        end
      end
      if (in_ch.valid && in_ch.ready)
        pending_results.push_back(evaluate_event(kind_e'(in_ch.kind), in_ch.now_ms,
                                                 in_ch.pong_id));
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Gap drawn per item by both sides; zero throughout a steady stretch.
  function automatic int pick_gap();
    if (steady) return 0;
    return $urandom_range(0, 16);
  endfunction

  // ---------------------------------------------------------------------
  // Result side: random stall before each item, then ready until it moves.
  // ---------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // ---------------------------------------------------------------------
  // Event side helpers
  // ---------------------------------------------------------------------

  // Sends one event item. Valid is left high after the handshake so a
  // zero gap on the next item keeps it high without a drop.
  task automatic send_event(kind_e kind, stamp_t now, logic [ID_W-1:0] pid);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= kind;
    in_ch.now_ms  <= now;
    in_ch.pong_id <= pid;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Holds off until every expected result item has come back.
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_register(cfg_idx_e idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_PING_INTERVAL:     settings.ping_interval     = value;
      REG_PING_TIMEOUT:      settings.ping_timeout      = value;
      REG_RECOVERY_INTERVAL: settings.recovery_interval = value;
      REG_RECOVERY_TIMEOUT:  settings.recovery_timeout  = value;
      REG_PING_ID:           settings.ping_id           = value[ID_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Registers change only with the pipeline empty.
  task automatic apply_settings(logic [CFG_W-1:0] ping_iv, logic [CFG_W-1:0] ping_to,
                                logic [CFG_W-1:0] rec_iv, logic [CFG_W-1:0] rec_to,
                                logic [ID_W-1:0] ident);
    wait_results_drained();
    set_register(REG_PING_INTERVAL, ping_iv);
    set_register(REG_PING_TIMEOUT, ping_to);
    set_register(REG_RECOVERY_INTERVAL, rec_iv);
    set_register(REG_RECOVERY_TIMEOUT, rec_to);
    set_register(REG_PING_ID, CFG_W'(ident));
    cfg_we <= 1'b0;
  endtask

  function automatic stamp_t any_stamp();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[TIME_WIDTH_DEF-1:0];
  endfunction

  function automatic logic [CFG_W-1:0] pick_span(int typical);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return CFG_W'($urandom_range(0, typical));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset settings (1000/5000/1000/15000, id 0): zero time, pong before
  // any ping, wrong id, reserved kind, recovery and timeout, backwards
  // pong, saturated round trip, stamps cleared back to zero.
  task automatic test_default_settings();
    send_event(KIND_TICK, 48'd0, 16'h0000);
    send_event(KIND_TICK, 48'd1000, 16'hFFFF);     // exactly the interval: no ping
    send_event(KIND_PONG, 48'd900, 16'h0000);      // no ping sent yet: measured from zero
    send_event(KIND_TICK, 48'd1001, 16'h0000);     // first ping
    send_event(KIND_PONG, 48'd1200, 16'hFFFF);     // other id, dropped
    send_event(KIND_PONG, 48'd1100, 16'h0000);
    send_event(KIND_RSVD, 48'd1300, 16'hA5A5);
    send_event(KIND_TICK, 48'd7000, 16'h0000);     // ping plus first recovery
    send_event(KIND_TICK, 48'd7500, 16'h0000);     // recovery interval not yet up
    send_event(KIND_TICK, 48'd30000, 16'h0000);    // timed out
    send_event(KIND_ACK, 48'd30001, 16'h0000);
    send_event(KIND_TICK, 48'd30002, 16'h0000);
    send_event(KIND_PONG, 48'd25000, 16'h0000);    // earlier than request: zero trip
    send_event(KIND_PONG, 48'd200000, 16'h0000);   // long trip saturates
    send_event(KIND_PONG, 48'd0, 16'h0000);        // response and ack back to unset
    send_event(KIND_TICK, 48'd201500, 16'h0000);   // ping seeds response time again
    send_event(KIND_ACK, 48'd0, 16'h0000);
  endtask

  // All spans zero with id all ones, then all spans at full scale.
  task automatic test_setting_extremes();
    apply_settings('0, '0, '0, '0, 16'hFFFF);
    send_event(KIND_TICK, 48'd201501, 16'h0000);   // ping and recovery fire, ack seeded, no timeout
    send_event(KIND_TICK, 48'd201501, 16'h0000);   // same time: nothing elapsed
    send_event(KIND_PONG, 48'd201550, 16'h0000);   // other id
    send_event(KIND_PONG, 48'd201600, 16'hFFFF);
    send_event(KIND_TICK, 48'd201602, 16'h0000);
    apply_settings('1, '1, '1, '1, 16'h5A5A);
    send_event(KIND_TICK, 48'd201700, 16'h0000);
    send_event(KIND_PONG, 48'd201800, 16'h5A5A);
    send_event(KIND_TICK, 48'd201800 + 48'd1048576, 16'h0000);
  endtask

  // One random event of a running session. Most items are ticks and
  // matching pongs on a forward clock; the rest is noise.
  task automatic session_item();
    int              pick;
    stamp_t          step;
    logic [ID_W-1:0] pid;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 39))
      0:       step = stamp_t'($urandom_range(60000, 140000));   // long silence
      1, 2, 3: step = stamp_t'($urandom_range(0, 3000));
      default: step = stamp_t'($urandom_range(0, 60));
    endcase
    if (pick < 55) begin
      session_ms += step;
      send_event(KIND_TICK, session_ms, 16'(($urandom)));
    end else if (pick < 70) begin
      session_ms += stamp_t'($urandom_range(0, 20));
      send_event(KIND_PONG, session_ms, settings.ping_id);
    end else if (pick < 80) begin
      session_ms += stamp_t'($urandom_range(0, 20));
      send_event(KIND_ACK, session_ms, 16'(($urandom)));
    end else if (pick < 85) begin
      // pong stamped in the past
      send_event(KIND_PONG, session_ms - stamp_t'($urandom_range(0, 100)), settings.ping_id);
    end else if (pick < 93) begin
      pid = 16'($urandom);
      if (pid == settings.ping_id) pid = ~pid;
      send_event(KIND_PONG, any_stamp(), pid);
    end else
      send_event(KIND_RSVD, any_stamp(), 16'($urandom));
  endtask

  // Random settings per phase; one phase without idling, and every other
  // phase stops halfway until all results are back.
  task automatic test_random_sessions();
    session_ms = 48'd2000000;
    for (int phase = 0; phase < 8; phase++) begin
      apply_settings(pick_span(60), pick_span(400), pick_span(60), pick_span(600),
                     16'($urandom));
      steady = (phase == 2);
      for (int n = 0; n < 48; n++) begin
        if (n == 24 && phase % 2 == 1) wait_results_drained();
        session_item();
      end
      steady = 1'b0;
    end
  endtask

  // Top of the time range; request and recovery stamps can only move up,
  // so this runs last.
  task automatic test_time_ceiling();
    stamp_t high_stamp;
    apply_settings(CFG_W'(10), CFG_W'(10), CFG_W'(10), CFG_W'(10), 16'($urandom));
    repeat (4) begin
      high_stamp = any_stamp();
      high_stamp[TIME_WIDTH_DEF-1] = 1'b1;
      send_event(KIND_TICK, high_stamp, 16'h0000);
    end
    send_event(KIND_PONG, '1, settings.ping_id);
    send_event(KIND_ACK, '1, 16'hFFFF);
    send_event(KIND_TICK, '1, 16'hFFFF);
    send_event(KIND_TICK, '1, 16'h0000);
    send_event(KIND_PONG, '1, ~settings.ping_id);
    send_event(KIND_RSVD, '1, 16'hFFFF);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.kind    <= KIND_TICK;
    in_ch.now_ms  <= '0;
    in_ch.pong_id <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_PING_INTERVAL;
    cfg_wdata     <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_default_settings();
    test_setting_extremes();
    test_random_sessions();
    test_time_ceiling();

    // drain, then wait for anything stray to show up
    wait_results_drained();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected result items never came", $time, pending_results.size());
      failures++;
    end
    if (failures == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

[sim.f]
rtl/core/kpm_pkg.sv
rtl/core/kpm_if.sv
rtl/core/kpm_cfg.sv
rtl/core/kpm_core.sv
rtl/core/keepalive_ping_monitor.sv
bench/testbench.sv
